### hdl/i2p_pkg.sv
package i2p_pkg;

  // default operator stack depth
  localparam int unsigned StackDepthDef = 16;

  // ascii codes the converter treats specially
  localparam logic [7:0] ChrPlus   = 8'h2B;
  localparam logic [7:0] ChrMinus  = 8'h2D;
  localparam logic [7:0] ChrStar   = 8'h2A;
  localparam logic [7:0] ChrSlash  = 8'h2F;
  localparam logic [7:0] ChrCaret  = 8'h5E;
  localparam logic [7:0] ChrLparen = 8'h28;
  localparam logic [7:0] ChrRparen = 8'h29;

  typedef enum logic [1:0] {
    CLS_ALNUM,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPER
  } sym_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WAIT,
    ST_FLUSH,
    ST_FWAIT,
    ST_CLOSE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture the input beat
    logic push;      // push latched symbol
    logic pop;       // drop top entry
    logic emit_top;  // emit top entry as an item
    logic emit_sym;  // emit latched symbol as an item
    logic close;     // release held item, end the step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    sym_class_e cls;
    logic       eoe;
    logic       zero;
    logic       top_lparen;
    logic       pop_ok;
    logic       emit_ok;
    logic       out_free;
    logic       hold_v;
    logic       dropped;
  } sts_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == ChrPlus || c == ChrMinus) p = 2'd1;
    else if (c == ChrStar || c == ChrSlash) p = 2'd2;
    else if (c == ChrCaret) p = 2'd3;
    return p;
  endfunction

  function automatic sym_class_e classify(input logic [7:0] c);
    sym_class_e k;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) k = CLS_ALNUM;
    else if (c == ChrLparen) k = CLS_LPAREN;
    else if (c == ChrRparen) k = CLS_RPAREN;
    else k = CLS_OPER;
    return k;
  endfunction

endpackage

### hdl/i2p_in_if.sv
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

### hdl/i2p_out_if.sv
interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       has_symbol;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_symbol, output has_symbol, output last,
                  output overflow, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol, input last,
                  input overflow, output ready);
endinterface

### hdl/i2p_ram.sv
module i2p_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/i2p_datapath.sv
module i2p_datapath
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] in_symbol_i,
  input  logic       in_end_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_symbol_o,
  output logic       has_symbol_o,
  output logic       last_o,
  output logic       overflow_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [7:0]    sym_q;
  logic          eoe_q;
  logic [CW-1:0] count_q, count_d, count_dec;
  logic          dropped_q, dropped_d;
  logic [7:0]    hold_sym_q, hold_sym_d;
  logic          hold_has_q, hold_has_d;
  logic          hold_v_q, hold_v_d;
  logic          out_v_q, out_v_d;
  logic [7:0]    out_sym_q, out_sym_d;
  logic          out_has_q, out_has_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;
  logic [7:0]    top;
  logic          zero, full, out_free, emit, load;
  logic [7:0]    new_sym;

  assign count_dec = count_q - {{(CW-1){1'b0}}, 1'b1};
  assign zero      = (count_q == '0);
  assign full      = (count_q == CW'(STACK_DEPTH));
  assign out_free  = !out_v_q || out_ready_i;
  assign emit      = cmd_i.emit_top || cmd_i.emit_sym;
  assign new_sym   = cmd_i.emit_top ? top : sym_q;

  // operator stack storage, read address tracks the top entry
  i2p_ram #(
    .Width(8),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push && !full),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(sym_q),
    .raddr_i(count_dec[AW-1:0]),
    .rdata_o(top)
  );

  // status to the controller
  always_comb begin
    sts_o.cls        = classify(sym_q);
    sts_o.eoe        = eoe_q;
    sts_o.zero       = zero;
    sts_o.top_lparen = (top == ChrLparen);
    sts_o.pop_ok     = !zero && (top != ChrLparen) && (prec_of(top) >= prec_of(sym_q));
    sts_o.emit_ok    = !hold_v_q || out_free;
    sts_o.out_free   = out_free;
    sts_o.hold_v     = hold_v_q;
    sts_o.dropped    = dropped_q;
  end

  // stack count and drop flag
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.latch) dropped_d = 1'b0;
    if (cmd_i.push) begin
      if (full) dropped_d = 1'b1;
      else count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end
  end

  // one item held back so the final one can carry last
  always_comb begin
    hold_sym_d = hold_sym_q;
    hold_has_d = hold_has_q;
    hold_v_d   = hold_v_q;
    out_sym_d  = out_sym_q;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    load       = 1'b0;
    if (emit) begin
      if (hold_v_q) begin
        load       = 1'b1;
        out_sym_d  = hold_sym_q;
        out_has_d  = hold_has_q;
        out_last_d = 1'b0;
        out_ovf_d  = dropped_q;
      end
      hold_sym_d = new_sym;
      hold_has_d = 1'b1;
      hold_v_d   = 1'b1;
    end else if (cmd_i.close) begin
      if (hold_v_q) begin
        load       = 1'b1;
        out_sym_d  = hold_sym_q;
        out_has_d  = hold_has_q;
        out_last_d = eoe_q;
        out_ovf_d  = dropped_q;
      end else if (eoe_q || dropped_q) begin
        load       = 1'b1;
        out_sym_d  = 8'h00;
        out_has_d  = 1'b0;
        out_last_d = eoe_q;
        out_ovf_d  = dropped_q;
      end
      hold_v_d = 1'b0;
    end
    out_v_d = load || (out_v_q && !out_ready_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sym_q <= in_symbol_i;
      eoe_q <= in_end_i;
    end
    hold_sym_q <= hold_sym_d;
    hold_has_q <= hold_has_d;
    out_sym_q  <= out_sym_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_symbol_o = out_sym_q;
  assign has_symbol_o = out_has_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;

  // stack count stays within depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // no pop from an empty stack
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !zero)
    else $error("pop on empty stack");

  // a pop lowers the count by one
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop && !cmd_i.push |=> count_q == $past(count_dec))
    else $error("pop did not decrement count");

  // output register is never overwritten while a beat is pending
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("output beat overwritten");

endmodule

### hdl/i2p_ctrl.sv
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        close_ok;

  // closing needs the output register when something is sent
  assign close_ok = !(sts_i.hold_v || sts_i.eoe || sts_i.dropped) || sts_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: begin
        unique case (sts_i.cls)
          CLS_ALNUM: begin
            if (sts_i.emit_ok) state_d = sts_i.eoe ? ST_FLUSH : ST_CLOSE;
          end
          CLS_LPAREN: state_d = sts_i.eoe ? ST_FWAIT : ST_CLOSE;
          CLS_RPAREN: begin
            priority if (sts_i.zero) state_d = sts_i.eoe ? ST_FLUSH : ST_CLOSE;
            else if (sts_i.top_lparen) state_d = sts_i.eoe ? ST_FWAIT : ST_CLOSE;
            else if (sts_i.emit_ok) state_d = ST_WAIT;
            else state_d = ST_EVAL;
          end
          CLS_OPER: begin
            priority if (sts_i.pop_ok) begin
              if (sts_i.emit_ok) state_d = ST_WAIT;
            end else state_d = sts_i.eoe ? ST_FWAIT : ST_CLOSE;
          end
          default: state_d = ST_CLOSE;
        endcase
      end
      ST_WAIT:  state_d = ST_EVAL;
      ST_FLUSH: begin
        priority if (sts_i.zero) state_d = ST_CLOSE;
        else if (sts_i.emit_ok) state_d = ST_FWAIT;
        else state_d = ST_FLUSH;
      end
      ST_FWAIT: state_d = ST_FLUSH;
      ST_CLOSE: if (close_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EVAL: begin
        unique case (sts_i.cls)
          CLS_ALNUM:  cmd_o.emit_sym = sts_i.emit_ok;
          CLS_LPAREN: cmd_o.push = 1'b1;
          CLS_RPAREN: begin
            priority if (sts_i.zero) cmd_o.pop = 1'b0;
            else if (sts_i.top_lparen) cmd_o.pop = 1'b1;
            else begin
              cmd_o.pop      = sts_i.emit_ok;
              cmd_o.emit_top = sts_i.emit_ok;
            end
          end
          CLS_OPER: begin
            priority if (sts_i.pop_ok) begin
              cmd_o.pop      = sts_i.emit_ok;
              cmd_o.emit_top = sts_i.emit_ok;
            end else cmd_o.push = 1'b1;
          end
          default: cmd_o = '0;
        endcase
      end
      ST_FLUSH: begin
        cmd_o.pop      = !sts_i.zero && sts_i.emit_ok;
        cmd_o.emit_top = !sts_i.zero && sts_i.emit_ok;
      end
      ST_CLOSE: cmd_o.close = close_ok;
      ST_WAIT, ST_FWAIT: cmd_o = '0;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a new beat is only taken once the previous step is closed
  a_latch_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |-> !sts_i.hold_v)
    else $error("held item left over from previous step");

  // every pop moves to ST_WAIT, ST_FWAIT or ST_CLOSE so the stack read settles
  a_pop_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == ST_WAIT || state_q == ST_FWAIT || state_q == ST_CLOSE))
    else $error("stack top used before read settled");

endmodule

### hdl/infix_to_postfix_converter_unit.sv
// Shunting-yard infix to postfix converter. One ASCII character is taken per
// input beat, with end_of_expression on the final one; operands pass through,
// operators are reordered on an internal stack of STACK_DEPTH entries and the
// stack is flushed at the end, the last result beat marked with last. A push
// onto a full stack is dropped and every beat sent after that within the
// character carries overflow; a character that yields nothing but ends the
// expression or drops a push gives one bare beat with has_symbol low. Each
// popped operator is emitted and then waits for the stack memory's registered
// read to present the new top; the final character flushes the remaining
// entries the same way, and one that pushes (or tries to push) or discards a
// '(' also waits for that read before the flush. Output back-pressure stalls
// the converter.
// The stack memory needs no clearing after reset.
module infix_to_postfix_converter_unit
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2p_in_if.sink     in_i,
  i2p_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  i2p_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_symbol_i (in_i.symbol),
    .in_end_i    (in_i.end_of_expression),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_symbol_o(out_o.out_symbol),
    .has_symbol_o(out_o.has_symbol),
    .last_o      (out_o.last),
    .overflow_o  (out_o.overflow)
  );

endmodule
